>>> rtl/cpsp_pkg.sv
// Shared types and constants for the cascade position and speed PID block.
`default_nettype none

package cpsp_pkg;

  // Field widths of the ports.
  localparam int POS_W     = 24;
  localparam int SPD_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 15;
  localparam int DRV_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Internal arithmetic widths.
  localparam int PE_W   = 25;  // position error
  localparam int PD_W   = 26;  // position error difference
  localparam int SUM_W  = 40;  // saturated error sums
  localparam int RES_W  = 32;  // saturated stage result
  localparam int SE_W   = 33;  // speed error
  localparam int SD_W   = 34;  // speed error difference
  localparam int HALF_W = 20;  // operand half fed to the multiplier
  localparam int OP_W   = HALF_W + 1;
  localparam int PROD_W = GAIN_W + OP_W;
  localparam int ACC_W  = 58;
  localparam int STEP_W = 3;

  // Six partial products per stage: three terms, two operand halves each.
  localparam logic [STEP_W-1:0] MUL_LAST = 3'd5;

  localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [RES_W-1:0] RES_MIN = 32'sh8000_0000;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KI      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_KD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_KP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_KI      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_KD      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd6;

  // Register reset values.
  localparam logic signed [GAIN_W-1:0] POS_KP_RST = 16'sd2816;
  localparam logic signed [GAIN_W-1:0] POS_KI_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] POS_KD_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] SPD_KP_RST = 16'sd256;
  localparam logic signed [GAIN_W-1:0] SPD_KI_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] SPD_KD_RST = 16'sd51;
  localparam logic [LIM_W-1:0]         LIMIT_RST  = 15'd5000;

  // PID term selected for the multiplier.
  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_OPREP  = 10'b00_0000_0010,
    S_OMUL   = 10'b00_0000_0100,
    S_ODRAIN = 10'b00_0000_1000,
    S_OSCALE = 10'b00_0001_0000,
    S_SPREP  = 10'b00_0010_0000,
    S_SMUL   = 10'b00_0100_0000,
    S_SDRAIN = 10'b00_1000_0000,
    S_SSCALE = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] pos_kp;
    logic signed [GAIN_W-1:0] pos_ki;
    logic signed [GAIN_W-1:0] pos_kd;
    logic signed [GAIN_W-1:0] spd_kp;
    logic signed [GAIN_W-1:0] spd_ki;
    logic signed [GAIN_W-1:0] spd_kd;
    logic [LIM_W-1:0]         drive_limit;
  } gains_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load_in;
    logic  prep_pos;
    logic  prep_spd;
    logic  mul_en;
    term_t term;
    logic  hi;
    logic  inner;
    logic  scale;
    logic  out_load;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/cascade_position_speed_pid.sv
// Top level of the cascade position and speed PID controller.
`default_nettype none

// One word is taken per control tick and gives exactly one drive word. A word
// is accepted only while the block is idle; its result is loaded into the
// output register after both stages. The pace is set by the single shared
// 16 x 21 bit multiplier: each stage forms six partial products (three PID
// terms, two operand halves each) between a setup state and a drain and a
// scale state. A new word may be accepted while the previous drive word still
// waits on the output; its own result is then held until the waiting word is
// taken. The user must write gains and the drive limit through the configuration
// port only while no word is in flight; the block itself does not enforce this.

module cascade_position_speed_pid #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cpsp_pkg::POS_W-1:0]     in_position_target,
  input  logic signed [cpsp_pkg::POS_W-1:0]     in_position_measured,
  input  logic signed [cpsp_pkg::SPD_W-1:0]     in_speed_measured,
  input  logic                                  in_clear,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [cpsp_pkg::DRV_W-1:0]     out_drive,
  output logic                                  out_limited,
  input  logic                                  cfg_we,
  input  logic [cpsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpsp_pkg::CFG_DAT_W-1:0]        cfg_data
);
  import cpsp_pkg::*;

  gains_t gains_r, gains_nxt;
  cmd_t   cmd;

  // Configuration register file; unknown indexes are ignored.
  always_comb begin
    gains_nxt = gains_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_POS_KP:      gains_nxt.pos_kp      = $signed(cfg_data);
        CFG_POS_KI:      gains_nxt.pos_ki      = $signed(cfg_data);
        CFG_POS_KD:      gains_nxt.pos_kd      = $signed(cfg_data);
        CFG_SPD_KP:      gains_nxt.spd_kp      = $signed(cfg_data);
        CFG_SPD_KI:      gains_nxt.spd_ki      = $signed(cfg_data);
        CFG_SPD_KD:      gains_nxt.spd_kd      = $signed(cfg_data);
        CFG_DRIVE_LIMIT: gains_nxt.drive_limit = cfg_data[LIM_W-1:0];
        default: begin
          gains_nxt = gains_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.pos_kp      <= POS_KP_RST;
      gains_r.pos_ki      <= POS_KI_RST;
      gains_r.pos_kd      <= POS_KD_RST;
      gains_r.spd_kp      <= SPD_KP_RST;
      gains_r.spd_ki      <= SPD_KI_RST;
      gains_r.spd_kd      <= SPD_KD_RST;
      gains_r.drive_limit <= LIMIT_RST;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  cpsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cpsp_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .gains             (gains_r),
    .position_target   (in_position_target),
    .position_measured (in_position_measured),
    .speed_measured    (in_speed_measured),
    .clear             (in_clear),
    .drive             (out_drive),
    .limited           (out_limited)
  );

  // Limit as a signed drive value for the checks below.
  logic signed [DRV_W-1:0] lim_chk;
  assign lim_chk = $signed({1'b0, gains_r.drive_limit});

  // A word in flight keeps the input closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again right after a word was taken");

  // A clamped result sits exactly on one of the two limits.
  a_limited_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_limited) |-> ((out_drive == lim_chk) || (out_drive == -lim_chk)))
    else $error("clamped drive word is not at the limit");

  // An unclamped result lies within the limits.
  a_free_within_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_limited) |-> ((out_drive <= lim_chk) && (out_drive >= -lim_chk)))
    else $error("unclamped drive word exceeds the limit");

endmodule

`default_nettype wire

>>> rtl/cpsp_ctrl.sv
// Controller state machine that sequences the two PID stages.
`default_nettype none

module cpsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output cpsp_pkg::cmd_t cmd
);
  import cpsp_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.term  = term_t'(step_r[2:1]);
    cmd.hi    = step_r[0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_OPREP;
        end
      end
      S_OPREP: begin
        cmd.prep_pos = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_OMUL;
      end
      S_OMUL: begin
        cmd.mul_en = 1'b1;
        if (step_r == MUL_LAST) begin
          state_nxt = S_ODRAIN;
        end else begin
          step_nxt = STEP_W'(step_r + 3'd1);
        end
      end
      S_ODRAIN: begin
        state_nxt = S_OSCALE;
      end
      S_OSCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_SPREP;
      end
      S_SPREP: begin
        cmd.prep_spd = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_SMUL;
      end
      S_SMUL: begin
        cmd.mul_en = 1'b1;
        cmd.inner  = 1'b1;
        if (step_r == MUL_LAST) begin
          state_nxt = S_SDRAIN;
        end else begin
          step_nxt = STEP_W'(step_r + 3'd1);
        end
      end
      S_SDRAIN: begin
        state_nxt = S_SSCALE;
      end
      S_SSCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Wait until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/cpsp_dp.sv
// Datapath: error history, shared multiplier, accumulator, scaling and clamp.
`default_nettype none

module cpsp_dp #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cpsp_pkg::cmd_t                        cmd,
  input  cpsp_pkg::gains_t                      gains,
  input  logic signed [cpsp_pkg::POS_W-1:0]     position_target,
  input  logic signed [cpsp_pkg::POS_W-1:0]     position_measured,
  input  logic signed [cpsp_pkg::SPD_W-1:0]     speed_measured,
  input  logic                                  clear,
  output logic signed [cpsp_pkg::DRV_W-1:0]     drive,
  output logic                                  limited
);
  import cpsp_pkg::*;

  localparam int SH_W = ACC_W - GAIN_FRAC_BITS;

  // Saturate a sum that grew by one bit back to the sum width.
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] res;
    if (v[SUM_W] != v[SUM_W-1]) begin
      res = v[SUM_W] ? $signed({1'b1, {(SUM_W-1){1'b0}}})
                     : $signed({1'b0, {(SUM_W-1){1'b1}}});
    end else begin
      res = v[SUM_W-1:0];
    end
    return res;
  endfunction

  logic signed [POS_W-1:0]  tgt_r, meas_r;
  logic signed [SPD_W-1:0]  spd_r;
  logic                     clr_r;

  logic signed [PE_W-1:0]   pe_r, last_pe_r;
  logic signed [PD_W-1:0]   pd_r;
  logic signed [SUM_W-1:0]  pos_sum_r, spd_sum_r;
  logic signed [SE_W-1:0]   se_r, last_se_r;
  logic signed [SD_W-1:0]   sd_r;
  logic signed [RES_W-1:0]  res_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_hi_r, prod_vld_r;
  logic signed [DRV_W-1:0]  drive_r;
  logic                     limited_r;

  logic signed [PE_W-1:0]   pe_w, last_pe_eff;
  logic signed [SUM_W-1:0]  pos_sum_eff, pos_sum_w, spd_sum_w;
  logic signed [PD_W-1:0]   pd_w;
  logic signed [SE_W-1:0]   se_w;
  logic signed [SD_W-1:0]   sd_w;

  // Capture the input word.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt_r  <= position_target;
      meas_r <= position_measured;
      spd_r  <= speed_measured;
      clr_r  <= clear;
    end
  end

  // Outer stage error terms; the clear flag drops the position history.
  assign pe_w        = PE_W'(tgt_r) - PE_W'(meas_r);
  assign last_pe_eff = clr_r ? '0 : last_pe_r;
  assign pos_sum_eff = clr_r ? '0 : pos_sum_r;
  assign pos_sum_w   = sat_sum((SUM_W+1)'(pos_sum_eff) + (SUM_W+1)'(pe_w));
  assign pd_w        = PD_W'(pe_w) - PD_W'(last_pe_eff);

  // Inner stage error terms from the position command.
  assign se_w      = SE_W'(res_r) - SE_W'(spd_r);
  assign spd_sum_w = sat_sum((SUM_W+1)'(spd_sum_r) + (SUM_W+1)'(se_w));
  assign sd_w      = SD_W'(se_w) - SD_W'(last_se_r);

  // Error history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pe_r <= '0;
      pos_sum_r <= '0;
      last_se_r <= '0;
      spd_sum_r <= '0;
    end else begin
      if (cmd.prep_pos) begin
        last_pe_r <= pe_w;
        pos_sum_r <= pos_sum_w;
      end
      if (cmd.prep_spd) begin
        last_se_r <= se_w;
        spd_sum_r <= spd_sum_w;
      end
    end
  end

  // Working operands of the current stage.
  always_ff @(posedge clk) begin
    if (cmd.prep_pos) begin
      pe_r <= pe_w;
      pd_r <= pd_w;
    end
    if (cmd.prep_spd) begin
      se_r <= se_w;
      sd_r <= sd_w;
    end
  end

  // Gain and operand selection for the shared multiplier.
  logic signed [GAIN_W-1:0] gain_sel;
  logic signed [SUM_W-1:0]  op_full;
  logic signed [OP_W-1:0]   op_half;
  logic signed [PROD_W-1:0] mul_w;

  always_comb begin
    gain_sel = '0;
    op_full  = '0;
    case (cmd.term)
      TERM_P: begin
        gain_sel = cmd.inner ? gains.spd_kp : gains.pos_kp;
        op_full  = cmd.inner ? SUM_W'(se_r) : SUM_W'(pe_r);
      end
      TERM_I: begin
        gain_sel = cmd.inner ? gains.spd_ki : gains.pos_ki;
        op_full  = cmd.inner ? spd_sum_r : pos_sum_r;
      end
      TERM_D: begin
        gain_sel = cmd.inner ? gains.spd_kd : gains.pos_kd;
        op_full  = cmd.inner ? SUM_W'(sd_r) : SUM_W'(pd_r);
      end
      default: begin
        gain_sel = '0;
        op_full  = '0;
      end
    endcase
  end

  // The low half is unsigned, the high half carries the sign.
  assign op_half = cmd.hi ? $signed({op_full[SUM_W-1], op_full[SUM_W-1:HALF_W]})
                          : $signed({1'b0, op_full[HALF_W-1:0]});
  assign mul_w   = gain_sel * op_half;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r    <= mul_w;
      prod_hi_r <= cmd.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
    end
  end

  // Accumulate partial products, high halves weighted by the half width.
  logic signed [ACC_W-1:0] prod_ext, addend;

  assign prod_ext = ACC_W'(prod_r);
  assign addend   = prod_hi_r ? (prod_ext <<< HALF_W) : prod_ext;

  always_ff @(posedge clk) begin
    if (cmd.prep_pos || cmd.prep_spd) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + addend;
    end
  end

  // Drop the gain fraction with a floor shift and saturate to the result width.
  logic signed [SH_W-1:0]        sh_w;
  logic [SH_W-RES_W:0]           upper_w;
  logic                          ovf_w;
  logic signed [RES_W-1:0]       res_sat;

  assign sh_w    = $signed(acc_r[ACC_W-1:GAIN_FRAC_BITS]);
  assign upper_w = sh_w[SH_W-1:RES_W-1];
  assign ovf_w   = !((&upper_w) || !(|upper_w));
  assign res_sat = ovf_w ? (sh_w[SH_W-1] ? RES_MIN : RES_MAX) : sh_w[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      res_r <= res_sat;
    end
  end

  // Clamp the drive value to the symmetric limit.
  logic signed [RES_W-1:0] lim_pos, lim_neg;
  logic signed [DRV_W-1:0] drive_nxt;
  logic                    limited_nxt;

  assign lim_pos = $signed({{(RES_W-LIM_W){1'b0}}, gains.drive_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    drive_nxt   = res_r[DRV_W-1:0];
    limited_nxt = 1'b0;
    if (res_r > lim_pos) begin
      drive_nxt   = lim_pos[DRV_W-1:0];
      limited_nxt = 1'b1;
    end else if (res_r < lim_neg) begin
      drive_nxt   = lim_neg[DRV_W-1:0];
      limited_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive_r   <= drive_nxt;
      limited_r <= limited_nxt;
    end
  end

  assign drive   = drive_r;
  assign limited = limited_r;

endmodule

`default_nettype wire
